// ===== rtl/core/ihf_pkg.sv =====
`default_nettype none
package ihf_pkg;

    // Command queue depth between the request front end and the text engine.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_ADDR = 2'd1;
    localparam logic [1:0] REQ_EOS  = 2'd2;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_ADDR = 2'd1,
        OP_EOS  = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] arg;
    } t_cmd;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Index of the final character of the end-of-file record.
    localparam logic [5:0] EOF_LAST_POS = 6'd11;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    // Text of the end-of-file record ":00000001FF" plus newline.
    function automatic logic [7:0] eof_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_COLON;
            4'd8:    c = 8'h31;
            4'd9:    c = 8'h46;
            4'd10:   c = 8'h46;
            4'd11:   c = CH_NEWLINE;
            default: c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ihf_if.sv =====
`default_nettype none
interface ihf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] new_address;

    modport source (output valid, output req_type, output data_byte, output new_address,
                    input ready);
    modport sink   (input valid, input req_type, input data_byte, input new_address,
                    output ready);
endinterface

interface ihf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ihf_front.sv =====
`default_nettype none
module ihf_front (
    ihf_req_if.sink        i_req,
    input  wire logic      i_q_full,
    output ihf_pkg::t_cmd  o_cmd,
    output logic           o_push
);
    import ihf_pkg::*;

    logic w_keep;

    // Unused request codes are taken and dropped without reaching the queue.
    always_comb begin
        w_keep    = 1'b1;
        o_cmd.arg = {8'd0, i_req.data_byte};
        o_cmd.op  = OP_DATA;
        case (i_req.req_type)
            REQ_DATA: begin
                o_cmd.op  = OP_DATA;
                o_cmd.arg = {8'd0, i_req.data_byte};
            end
            REQ_ADDR: begin
                o_cmd.op  = OP_ADDR;
                o_cmd.arg = i_req.new_address;
            end
            REQ_EOS: begin
                o_cmd.op  = OP_EOS;
                o_cmd.arg = i_req.new_address;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full && w_keep;

endmodule
`default_nettype wire

// ===== rtl/core/ihf_queue.sv =====
`default_nettype none
module ihf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ihf_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output ihf_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import ihf_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ihf_back.sv =====
`default_nettype none
module ihf_back #(
    parameter int unsigned RECORD_BYTES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire ihf_pkg::t_cmd i_cmd,
    output logic               o_cmd_ready,
    ihf_text_if.source         o_text
);
    import ihf_pkg::*;

    localparam int unsigned IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_REC  = 3'b010,
        ST_EOF  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        AF_NONE = 2'd0,
        AF_LOAD = 2'd1,
        AF_EOF  = 2'd2
    } t_after;

    t_state      r_state, n_state;
    t_after      r_after, n_after;
    logic [4:0]  r_fill, n_fill;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_naddr, n_naddr;
    logic [7:0]  r_dsum, n_dsum;
    logic [4:0]  r_cnt, n_cnt;
    logic [7:0]  r_ck, n_ck;
    logic [5:0]  r_pos, n_pos;
    logic        r_ov, n_ov;
    logic [7:0]  r_ch, n_ch;
    logic        r_last, n_last;
    logic [7:0]  r_buf [RECORD_BYTES];

    logic        w_free;
    logic        w_pop;
    logic        w_wr;
    logic [4:0]  w_fill_inc;
    logic [7:0]  w_dsum_inc;
    logic        w_flush;
    logic [4:0]  w_fl_cnt;
    logic [7:0]  w_fl_dsum;
    logic [5:0]  w_two_cnt;
    logic [5:0]  w_last_pos;
    logic [5:0]  w_d;
    logic [7:0]  w_byte;
    logic [7:0]  w_rec_ch;

    assign w_free      = !r_ov || o_text.ready;
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_wr        = w_pop && (i_cmd.op == OP_DATA);
    assign w_fill_inc  = r_fill + 5'd1;
    assign w_dsum_inc  = r_dsum + i_cmd.arg[7:0];
    assign w_two_cnt   = {r_cnt, 1'b0};
    assign w_last_pos  = 6'd11 + w_two_cnt;
    assign w_d         = r_pos - 6'd9;
    assign w_byte      = r_buf[w_d[IDX_W:1]];

    // Character at the current position of a data record.
    always_comb begin
        if (r_pos == 6'd0) begin
            w_rec_ch = CH_COLON;
        end else if (r_pos == 6'd1) begin
            w_rec_ch = hex_char({3'd0, r_cnt[4]});
        end else if (r_pos == 6'd2) begin
            w_rec_ch = hex_char(r_cnt[3:0]);
        end else if (r_pos == 6'd3) begin
            w_rec_ch = hex_char(r_addr[15:12]);
        end else if (r_pos == 6'd4) begin
            w_rec_ch = hex_char(r_addr[11:8]);
        end else if (r_pos == 6'd5) begin
            w_rec_ch = hex_char(r_addr[7:4]);
        end else if (r_pos == 6'd6) begin
            w_rec_ch = hex_char(r_addr[3:0]);
        end else if (r_pos < 6'd9) begin
            w_rec_ch = CH_ZERO;
        end else if (w_d < w_two_cnt) begin
            w_rec_ch = w_d[0] ? hex_char(w_byte[3:0]) : hex_char(w_byte[7:4]);
        end else if (w_d == w_two_cnt) begin
            w_rec_ch = hex_char(r_ck[7:4]);
        end else if (w_d == w_two_cnt + 6'd1) begin
            w_rec_ch = hex_char(r_ck[3:0]);
        end else begin
            w_rec_ch = CH_NEWLINE;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_fill    = r_fill;
        n_addr    = r_addr;
        n_naddr   = r_naddr;
        n_dsum    = r_dsum;
        n_cnt     = r_cnt;
        n_ck      = r_ck;
        n_pos     = r_pos;
        n_ov      = r_ov && !o_text.ready;
        n_ch      = r_ch;
        n_last    = r_last;
        w_flush   = 1'b0;
        w_fl_cnt  = r_fill;
        w_fl_dsum = r_dsum;

        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    case (i_cmd.op)
                        OP_DATA: begin
                            n_fill = w_fill_inc;
                            n_dsum = w_dsum_inc;
                            if (w_fill_inc >= 5'(RECORD_BYTES)) begin
                                w_flush   = 1'b1;
                                w_fl_cnt  = w_fill_inc;
                                w_fl_dsum = w_dsum_inc;
                                n_after   = AF_NONE;
                            end
                        end
                        OP_ADDR: begin
                            if (r_fill != 5'd0) begin
                                w_flush = 1'b1;
                                n_after = AF_LOAD;
                                n_naddr = i_cmd.arg;
                            end else begin
                                n_addr = i_cmd.arg;
                            end
                        end
                        OP_EOS: begin
                            if (r_fill != 5'd0) begin
                                w_flush = 1'b1;
                                n_after = AF_EOF;
                            end else begin
                                n_state = ST_EOF;
                                n_pos   = '0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                    if (w_flush) begin
                        n_state = ST_REC;
                        n_pos   = '0;
                        n_cnt   = w_fl_cnt;
                        n_ck    = 8'd0 - ({3'd0, w_fl_cnt} + r_addr[15:8] + r_addr[7:0]
                                          + w_fl_dsum);
                    end
                end
            end
            ST_REC: begin
                if (w_free) begin
                    n_ov   = 1'b1;
                    n_ch   = w_rec_ch;
                    n_last = (r_pos == w_last_pos) && (r_after != AF_EOF);
                    n_pos  = r_pos + 6'd1;
                    if (r_pos == w_last_pos) begin
                        n_addr = r_addr + {11'd0, r_cnt};
                        n_fill = '0;
                        n_dsum = '0;
                        n_pos  = '0;
                        if (r_after == AF_LOAD) begin
                            n_addr = r_naddr;
                        end
                        n_state = (r_after == AF_EOF) ? ST_EOF : ST_IDLE;
                    end
                end
            end
            ST_EOF: begin
                if (w_free) begin
                    n_ov   = 1'b1;
                    n_ch   = eof_char(r_pos[3:0]);
                    n_last = (r_pos == EOF_LAST_POS);
                    n_pos  = r_pos + 6'd1;
                    if (r_pos == EOF_LAST_POS) begin
                        n_pos   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_fill[IDX_W-1:0]] <= i_cmd.arg[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= AF_NONE;
            r_fill  <= '0;
            r_addr  <= '0;
            r_dsum  <= '0;
            r_pos   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_fill  <= n_fill;
            r_addr  <= n_addr;
            r_dsum  <= n_dsum;
            r_pos   <= n_pos;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_naddr <= n_naddr;
        r_cnt   <= n_cnt;
        r_ck    <= n_ck;
        r_ch    <= n_ch;
        r_last  <= n_last;
    end

    assign o_text.valid     = r_ov;
    assign o_text.text_char = r_ch;
    assign o_text.last_char = r_last;

endmodule
`default_nettype wire

// ===== rtl/core/intel_hex_record_framer_top.sv =====
// A taken request with a used code enters the command queue; the back end pops it while idle,
// and the text of a record it closes is walked in ST_REC into the output register.
// Record text streams at one character per cycle while the sink takes it: 12 + 2*n characters
// for n data bytes, 12 for end of file. A data byte that does not close a record is only
// stored; a request that closes a record holds the engine while its characters are produced.
// Reset (i_rst_n low, synchronous) empties the queue, clears fill count, address and output.
`default_nettype none
module intel_hex_record_framer_top #(
    parameter int unsigned RECORD_BYTES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ihf_req_if.sink   i_req,
    ihf_text_if.source o_text
);
    import ihf_pkg::*;

    // The front end takes a request whenever the command queue has room, turns it
    // into a command and drops unused request codes. The queue lets the front end
    // keep taking requests while the back end is busy streaming a record.
    t_cmd w_fe_cmd;
    logic w_fe_push;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_be_ready;

    ihf_front u_front (
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_cmd    (w_fe_cmd),
        .o_push   (w_fe_push)
    );

    ihf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_push),
        .i_cmd   (w_fe_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_be_ready)
    );

    // The back end owns the record buffer, the fill count and the record address.
    // It stores data bytes, and when a record closes it walks the record text one
    // character per cycle into an output register, which holds while the sink stalls.
    // Buffered data bytes are not cleared by reset; only bytes of the open record are read.
    ihf_back #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_ready (w_be_ready),
        .o_text      (o_text)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the Intel HEX record framer.
module tb_top;
    import ihf_pkg::*;

    // Request code 3 has no meaning; the block must drop it without side effects.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RECORD_LEN     = 16;
    localparam int PHASE_REQS     = 56;     // counted random requests per idling phase
    localparam int HOLD_BURST     = 48;     // data bytes streamed while the output is held off
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int CYCLE_LIMIT    = 600000;

    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_LF    = 8'h0A;

    // One request waiting in the driver queue, with the idling mode it belongs to and
    // two flags: start the long output hold when it is offered, or wait until every
    // pending character has arrived before offering it.
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  byte_val;
        logic [15:0] addr;
        int          pace;
        bit          hold_rx;
        bit          drain_first;
    } t_pending_req;

    // One character of record text as the block should produce it.
    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } t_text_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ihf_req_if  req_if ();
    ihf_text_if text_if ();

    intel_hex_record_framer_top #(
        .RECORD_BYTES(RECORD_LEN)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_text (text_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pending_req pending_reqs[$];
    t_text_beat   expected_text[$];

    // Encoder state as seen by the bench: buffered bytes, bytes pending in the open
    // record, and the load address of that record.
    logic [7:0]  rec_bytes [RECORD_LEN];
    logic [4:0]  rec_fill = '0;
    logic [15:0] rec_addr = '0;

    string HEX_DIGITS = "0123456789ABCDEF";
    string EOF_TEXT   = ":00000001FF";

    // Idle percentages per pace: sender light / receiver heavy, then the reverse,
    // then no idling at all.
    int tx_idle_pct [3] = '{14, 69, 0};
    int rx_idle_pct [3] = '{69, 14, 0};

    int pace_mode      = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int rx_hold_left   = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int reqs_taken     = 0;
    int total_reqs     = 0;
    int records_framed = 0;
    int chars_checked  = 0;

    function automatic void emit_char(input logic [7:0] c);
        t_text_beat b;
        b.ch      = c;
        b.is_last = 1'b0;
        expected_text.push_back(b);
    endfunction

    function automatic void emit_hex8(input logic [7:0] v);
        emit_char(HEX_DIGITS[v[7:4]]);
        emit_char(HEX_DIGITS[v[3:0]]);
    endfunction

    // Closes the open record: header, data, checksum and newline, then moves the
    // record address past the bytes just written (wrapping at 16 bits).
    function automatic void flush_record();
        logic [7:0] sum;
        int         i;
        sum = {3'b000, rec_fill} + rec_addr[15:8] + rec_addr[7:0];
        emit_char(ASCII_COLON);
        emit_hex8({3'b000, rec_fill});
        emit_hex8(rec_addr[15:8]);
        emit_hex8(rec_addr[7:0]);
        emit_hex8(8'h00);
        for (i = 0; i < rec_fill; i++) begin
            emit_hex8(rec_bytes[i]);
            sum += rec_bytes[i];
        end
        emit_hex8(8'h00 - sum);
        emit_char(ASCII_LF);
        rec_addr = rec_addr + {11'd0, rec_fill};
        rec_fill = '0;
        records_framed++;
    endfunction

    // Works out the text that one accepted request produces and queues it; the
    // final character of that text carries the last flag.
    function automatic void predict_text(input logic [1:0] kind, input logic [7:0] byte_val,
                                         input logic [15:0] addr);
        int first;
        int i;
        first = expected_text.size();
        case (kind)
            REQ_DATA: begin
                rec_bytes[rec_fill[3:0]] = byte_val;
                rec_fill = rec_fill + 5'd1;
                if (rec_fill >= RECORD_LEN) flush_record();
            end
            REQ_ADDR: begin
                if (rec_fill != 0) flush_record();
                rec_addr = addr;
            end
            REQ_EOS: begin
                if (rec_fill != 0) flush_record();
                for (i = 0; i < EOF_TEXT.len(); i++) emit_char(EOF_TEXT[i]);
                emit_char(ASCII_LF);
            end
            default: ;
        endcase
        if (expected_text.size() > first) expected_text[$].is_last = 1'b1;
    endfunction

    function automatic void queue_request(input logic [1:0] kind, input logic [7:0] byte_val,
                                          input logic [15:0] addr, input int pace,
                                          input bit hold_rx, input bit drain_first);
        t_pending_req r;
        r.kind        = kind;
        r.byte_val    = byte_val;
        r.addr        = addr;
        r.pace        = pace;
        r.hold_rx     = hold_rx;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endfunction

    // Request driver. A request stays on the bus until it is taken; the expected text
    // is computed from the bus values at the edge where valid and ready are both high.
    // A new request is put up only when the bus is free, and the random idle draw can
    // leave the bus empty instead.
    always @(posedge i_clk) begin : request_driver
        t_pending_req nxt;
        bit           offer;
        if (!i_rst_n) begin
            req_if.valid       <= 1'b0;
            req_if.req_type    <= REQ_DATA;
            req_if.data_byte   <= 8'h00;
            req_if.new_address <= 16'h0000;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_text(req_if.req_type, req_if.data_byte, req_if.new_address);
                reqs_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                offer = 1'b0;
                if (pending_reqs.size() > 0) begin
                    // A request flagged to drain first waits until the block has
                    // delivered every character of what came before it.
                    offer = !(pending_reqs[0].drain_first && expected_text.size() != 0) &&
                            ($urandom_range(0, 99) >= tx_idle_pct[pending_reqs[0].pace]);
                end
                if (offer) begin
                    nxt = pending_reqs.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.req_type    <= nxt.kind;
                    req_if.data_byte   <= nxt.byte_val;
                    req_if.new_address <= nxt.addr;
                    pace_mode          <= nxt.pace;
                    if (nxt.hold_rx) hold_requests <= hold_requests + 1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold: counted here, apart from the monitor, so the sender keeps
    // streaming bytes while no character can leave and the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
            holds_served <= 0;
        end else if (holds_served != hold_requests) begin
            rx_hold_left <= RX_HOLD_CYCLES;
            holds_served <= hold_requests;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Text monitor. Every character taken is matched against the oldest expected one,
    // field by field; ready is redrawn each cycle from the idling mode unless a hold is on.
    always @(posedge i_clk) begin : text_monitor
        t_text_beat want;
        if (!i_rst_n) begin
            text_if.ready <= 1'b0;
        end else begin
            if (text_if.valid && text_if.ready) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    $error("text_char %h arrived with no character expected",
                           text_if.text_char);
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    if (text_if.text_char !== want.ch) begin
                        $error("text_char: expected %h, got %h", want.ch, text_if.text_char);
                        mismatches++;
                    end
                    if (text_if.last_char !== want.is_last) begin
                        $error("last_char: expected %b, got %b", want.is_last,
                               text_if.last_char);
                        mismatches++;
                    end
                end
            end
            text_if.ready <= (rx_hold_left == 0) &&
                             ($urandom_range(0, 99) >= rx_idle_pct[pace_mode]);
        end
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0]  walk_bytes [16];
        logic [15:0] a;
        int          p;
        int          i;
        int          r;
        int          burst;
        int          counted;
        bit          need_drain;

        walk_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h04, 8'h08,
                       8'h10, 8'h20, 8'h40, 8'h80, 8'h7F, 8'hFE, 8'h0F, 8'hF0};

        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_DATA;
        req_if.data_byte   = 8'h00;
        req_if.new_address = 16'h0000;
        text_if.ready      = 1'b0;

        // Directed part. End of stream with nothing pending gives the bare EOF record;
        // code 3 must be dropped; an address set with nothing pending only loads it.
        queue_request(REQ_EOS, 8'($urandom), 16'($urandom), 0, 1'b0, 1'b0);
        queue_request(REQ_UNUSED, 8'($urandom), 16'($urandom), 0, 1'b0, 1'b0);
        queue_request(REQ_ADDR, 8'($urandom), 16'hFFF8, 0, 1'b0, 1'b0);
        // A full record just below the top of the address space; the address wraps.
        for (i = 0; i < 16; i++) begin
            queue_request(REQ_DATA, walk_bytes[i], 16'($urandom), 0, 1'b0, 1'b0);
        end
        // A one-byte record flushed by end of stream, followed by the EOF record.
        queue_request(REQ_DATA, 8'hA5, 16'($urandom), 0, 1'b0, 1'b0);
        queue_request(REQ_EOS, 8'($urandom), 16'($urandom), 0, 1'b0, 1'b0);
        // The block keeps going after end of stream; a new address flushes a record
        // sitting at the very last address.
        queue_request(REQ_ADDR, 8'($urandom), 16'hFFFF, 0, 1'b0, 1'b0);
        queue_request(REQ_DATA, 8'h5A, 16'($urandom), 0, 1'b0, 1'b0);
        queue_request(REQ_ADDR, 8'($urandom), 16'h0000, 0, 1'b0, 1'b0);

        // Random part, one stretch per idling mode. Most traffic is an address set
        // followed by a burst of bytes, with end-of-stream requests and some noise.
        for (p = 0; p < 3; p++) begin
            counted    = 0;
            need_drain = (p == 1);
            if (p == 2) begin
                // The sender first waits for the block to go quiet, then streams
                // bytes at full rate while the output is held off.
                for (i = 0; i < HOLD_BURST; i++) begin
                    queue_request(REQ_DATA, 8'($urandom), 16'($urandom), p, i == 0, i == 0);
                end
            end
            while (counted < PHASE_REQS) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    queue_request(REQ_UNUSED, 8'($urandom), 16'($urandom), p, 1'b0, need_drain);
                end else if (r < 18) begin
                    queue_request(REQ_EOS, 8'($urandom), 16'($urandom), p, 1'b0, need_drain);
                    counted++;
                end else begin
                    if (r < 70) begin
                        a = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFC0, 16'hFFFF))
                                                        : 16'($urandom);
                        queue_request(REQ_ADDR, 8'($urandom), a, p, 1'b0, need_drain);
                        need_drain = 1'b0;
                        counted++;
                    end
                    burst = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                        : $urandom_range(1, 16);
                    for (i = 0; i < burst; i++) begin
                        queue_request(REQ_DATA, 8'($urandom), 16'($urandom), p, 1'b0,
                                      need_drain);
                        need_drain = 1'b0;
                    end
                    counted += burst;
                end
                need_drain = 1'b0;
            end
        end
        // Close out whatever record is still open.
        queue_request(REQ_EOS, 8'($urandom), 16'($urandom), 2, 1'b0, 1'b0);
        total_reqs = pending_reqs.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (reqs_taken != total_reqs || expected_text.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Framed %0d records from %0d requests; %0d characters checked.",
                 records_framed, reqs_taken, chars_checked);
        $display("Ran sender-heavy, receiver-heavy and full-rate idling, plus a %0d-cycle hold.",
                 RX_HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ihf_pkg.sv
rtl/core/ihf_if.sv
rtl/core/ihf_front.sv
rtl/core/ihf_queue.sv
rtl/core/ihf_back.sv
rtl/core/intel_hex_record_framer_top.sv
tb/sv/tb_top.sv
